/* hdl/cko_pkg.sv */
// Shared types, protocol constants and the protocol rule lookup for the checksum offload block.
package cko_pkg;

    // Word kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_ADDR   = 2'd1,
        OP_BYTE   = 2'd2,
        OP_FINISH = 2'd3
    } op_kind_t;

    // Result status carried on the output tuser.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_TOO_LONG    = 2'd2
    } status_t;

    localparam logic [7:0] PROTO_IP     = 8'd0;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_IGMP   = 8'd2;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam logic [4:0] OFF_IP   = 5'd10;
    localparam logic [4:0] OFF_ICMP = 5'd2;
    localparam logic [4:0] OFF_TCP  = 5'd16;
    localparam logic [4:0] OFF_UDP  = 5'd6;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One classified word as it travels through the queue.
    typedef struct packed {
        op_kind_t    kind;
        logic        is_ipv6;
        logic [7:0]  protocol;
        logic [15:0] operand;
    } op_t;

    // Checksum handling that follows from the IP version and protocol.
    typedef struct packed {
        logic       ok;
        logic       pseudo;
        logic [4:0] off;
    } rule_t;

    function automatic rule_t proto_rule(input logic ipv6, input logic [7:0] proto);
        rule_t r;
        r.ok     = 1'b1;
        r.pseudo = 1'b1;
        r.off    = 5'd0;
        case (proto)
            PROTO_IP:
            begin
                if (!ipv6)
                begin
                    r.off    = OFF_IP;
                    r.pseudo = 1'b0;
                end
            end
            PROTO_ICMP:
            begin
                r.off    = OFF_ICMP;
                r.pseudo = ipv6;
            end
            PROTO_IGMP:
            begin
                r.ok     = !ipv6;
                r.off    = OFF_ICMP;
                r.pseudo = 1'b0;
            end
            PROTO_TCP:    r.off = OFF_TCP;
            PROTO_UDP:    r.off = OFF_UDP;
            PROTO_ICMPV6:
            begin
                r.ok  = ipv6;
                r.off = OFF_ICMP;
            end
            default:      r.ok = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* hdl/internet_checksum_offload_top.sv */
// Top level of the internet checksum offload block: front, queue, back and assertions.
//
//  Channel | Direction | Handshake          | tdata                     | tuser
//  --------+-----------+--------------------+---------------------------+-------------
//  s_*     | in        | s_tvalid/s_tready  | is_ipv6,protocol,addr,byte| func
//  m_*     | out       | m_tvalid/m_tready  | checksum                  | status
//
// One word is accepted every cycle while the four-entry queue has room; the back retires
// one word per cycle, bounded by the single 32-bit accumulator add, except while a finish
// word waits on a stalled output. A finish word passes through the queue, the finish stage
// and then the fold-and-invert output register on its way to m_tvalid.
// rst_n clears the queue, the accumulator state and both result stages at once.
// A stalled output only holds back finish words and the words queued behind them; other words keep draining.
module internet_checksum_offload_top
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0 up: is_ipv6 [0], protocol [8:1], addr_word [24:9],
    // data_byte [32:25], zero fill [39:33].
    input  logic [39:0]  s_tdata,
    // s_tuser: func [1:0].
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: checksum [15:0].
    output logic [15:0]  m_tdata,
    // m_tuser: status [1:0].
    output logic [1:0]   m_tuser
);

    logic          op_valid;
    logic          op_ready;
    cko_pkg::op_t  op;

    // The front only classifies and queues; it holds no packet state.
    cko_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // The back owns the running sum, byte count and protocol rules.
    cko_back
    #(
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Any status other than ok must come with a zero checksum.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != cko_pkg::ST_OK) |-> (m_tdata == 16'd0))
        else $error("non-ok status with nonzero checksum");

    // A full queue means the back has a word waiting.
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> op_valid)
        else $error("input stalled while queue is empty");

    // The back may only stall on a finish word.
    a_stall_finish: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_ready |-> (op.kind == cko_pkg::OP_FINISH))
        else $error("back stalled on a non-finish word");

    // A finish word taken while the output is free passes through the finish stage and then shows up on m_tvalid.
    a_finish_latency: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_ready && (op.kind == cko_pkg::OP_FINISH) && !m_tvalid
        |=> ##1 m_tvalid)
        else $error("finish word produced no result");

endmodule

/* hdl/cko_front.sv */
// Input side: accepts stream words, classifies them and queues them for the back.
module cko_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [39:0]    s_tdata,
    input  logic [1:0]     s_tuser,
    output logic           op_valid,
    input  logic           op_ready,
    output cko_pkg::op_t   op
);

    cko_pkg::op_t                  q_mem [cko_pkg::QDEPTH];
    logic [cko_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cko_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cko_pkg::QPTR_W:0]      fill_reg, fill_next;
    cko_pkg::op_t                  in_op;
    logic                          push, pop;

    // The operand is the address word, or the payload byte in its low bits.
    always_comb
    begin
        in_op.kind     = cko_pkg::op_kind_t'(s_tuser);
        in_op.is_ipv6  = s_tdata[0];
        in_op.protocol = s_tdata[8:1];
        if (in_op.kind == cko_pkg::OP_BYTE)
            in_op.operand = {8'd0, s_tdata[32:25]};
        else
            in_op.operand = s_tdata[24:9];
    end

    assign s_tready = (fill_reg != (cko_pkg::QPTR_W+1)'(cko_pkg::QDEPTH));
    assign op_valid = (fill_reg != '0);
    assign op       = q_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (cko_pkg::QPTR_W+1)'(push) - (cko_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_op;
    end

endmodule

/* hdl/cko_back.sv */
// Execution side: accumulator, byte counter, finish stage and output register.
module cko_back
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  cko_pkg::op_t   op,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,
    output logic [1:0]     m_tuser
);

    logic [31:0]             sum_reg, sum_next;
    logic [LENGTH_BITS-1:0]  count_reg, count_next;
    logic                    v6_reg, v6_next;
    logic [7:0]              proto_reg, proto_next;
    logic                    long_reg, long_next;

    logic                    fin_valid_reg, fin_valid_next;
    logic [31:0]             fin_sum_reg, fin_sum_next;
    cko_pkg::status_t        fin_status_reg, fin_status_next;
    logic                    fin_zero_reg, fin_zero_next;

    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             out_cs_reg, out_cs_next;
    cko_pkg::status_t        out_status_reg, out_status_next;

    cko_pkg::rule_t          rule;
    logic                    take, fin_ready, out_ready, in_field;
    logic [LENGTH_BITS-1:0]  off_lo, off_hi;
    logic [16:0]             fold1, fold2;

    assign rule      = cko_pkg::proto_rule(v6_reg, proto_reg);
    assign out_ready = !out_valid_reg || m_tready;
    assign fin_ready = !fin_valid_reg || out_ready;
    assign op_ready  = (op.kind != cko_pkg::OP_FINISH) || fin_ready;
    assign take      = op_valid && op_ready;
    assign off_lo    = LENGTH_BITS'(rule.off);
    assign off_hi    = LENGTH_BITS'(rule.off + 5'd1);
    assign in_field  = rule.ok && ((count_reg == off_lo) || (count_reg == off_hi));

    always_comb
    begin
        sum_next        = sum_reg;
        count_next      = count_reg;
        v6_next         = v6_reg;
        proto_next      = proto_reg;
        long_next       = long_reg;
        fin_valid_next  = fin_valid_reg && !out_ready;
        fin_sum_next    = fin_sum_reg;
        fin_status_next = fin_status_reg;
        fin_zero_next   = fin_zero_reg;
        if (take)
        begin
            case (op.kind)
                cko_pkg::OP_START:
                begin
                    v6_next    = op.is_ipv6;
                    proto_next = op.protocol;
                    sum_next   = '0;
                    count_next = '0;
                    long_next  = 1'b0;
                end
                cko_pkg::OP_ADDR:
                begin
                    if (rule.pseudo)
                        sum_next = sum_reg + {16'd0, op.operand};
                end
                cko_pkg::OP_BYTE:
                begin
                    if (&count_reg)
                        long_next = 1'b1;
                    else
                    begin
                        if (!in_field)
                        begin
                            if (count_reg[0])
                                sum_next = sum_reg + {24'd0, op.operand[7:0]};
                            else
                                sum_next = sum_reg + {16'd0, op.operand[7:0], 8'd0};
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                cko_pkg::OP_FINISH:
                begin
                    fin_valid_next = 1'b1;
                    if (rule.pseudo)
                        fin_sum_next = sum_reg + {24'd0, proto_reg}
                                       + 32'(count_reg);
                    else
                        fin_sum_next = sum_reg;
                    if (!rule.ok)
                        fin_status_next = cko_pkg::ST_UNSUPPORTED;
                    else if (long_reg)
                        fin_status_next = cko_pkg::ST_TOO_LONG;
                    else
                        fin_status_next = cko_pkg::ST_OK;
                    fin_zero_next = !rule.ok || long_reg
                                    || (v6_reg && (proto_reg == cko_pkg::PROTO_IP));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Two folds of the carries back into the low half, then invert, or give zero when the result is forced to zero.
    always_comb
    begin
        fold1           = {1'b0, fin_sum_reg[31:16]} + {1'b0, fin_sum_reg[15:0]};
        fold2           = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
        out_valid_next  = out_valid_reg && !m_tready;
        out_cs_next     = out_cs_reg;
        out_status_next = out_status_reg;
        if (fin_valid_reg && out_ready)
        begin
            out_valid_next  = 1'b1;
            out_cs_next     = fin_zero_reg ? 16'd0 : ~fold2[15:0];
            out_status_next = fin_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            v6_reg        <= 1'b0;
            proto_reg     <= '0;
            long_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            v6_reg        <= v6_next;
            proto_reg     <= proto_next;
            long_reg      <= long_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_sum_reg    <= fin_sum_next;
        fin_status_reg <= fin_status_next;
        fin_zero_reg   <= fin_zero_next;
        out_cs_reg     <= out_cs_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cs_reg;
    assign m_tuser  = out_status_reg;

endmodule
